FILE: sv/dhte_pkg.sv
`default_nettype none

package dhte_pkg;

  // Command codes carried in the request beat
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  // Result status codes
  localparam logic [2:0] STS_INSERTED    = 3'd0;
  localparam logic [2:0] STS_FULL        = 3'd1;
  localparam logic [2:0] STS_FOUND       = 3'd2;
  localparam logic [2:0] STS_NOT_FOUND   = 3'd3;
  localparam logic [2:0] STS_REMOVED     = 3'd4;
  localparam logic [2:0] STS_REMOVE_MISS = 3'd5;
  localparam logic [2:0] STS_BAD_KEY     = 3'd6;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_REDUCE,
    S_READ,
    S_CHECK,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

FILE: sv/double_hash_table_engine.sv
// Double-hashing hash table with tombstones.
// Input channel (in_valid/in_ready/in_data): one beat is one request, a
// command (insert, search, remove) and a zero-padded key of KEY_BYTES bytes.
// Output channel (out_valid/out_ready/out_data): exactly one result beat per
// request, a status code and the slot that was written, found or removed.
// Each request runs alone. After the accept cycle the key's byte sum is
// reduced modulo TABLE_SLOTS and TABLE_SLOTS-1 in S_HASH and S_REDUCE: a
// quotient estimate by reciprocal multiplication, then the remainder with
// one correcting subtract. Each probe then has a read of the slot memory
// (S_READ) and a check that may write the slot back (S_CHECK).
// The next request is taken only once the result of the last one, or of a
// bad key or unused command, has gone to the output register. A request
// makes at most TABLE_SLOTS probes.
// The result sits in an output register, so a new request is taken while an
// earlier result still waits; if the receiver stalls, the next finished
// result holds in the engine and no further request is accepted.
// Reset empties the table at once through per-slot valid bits; no clearing
// pass is needed.
`default_nettype none

module double_hash_table_engine #(
  parameter int TABLE_SLOTS = 16,
  parameter int KEY_BYTES   = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire dhte_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output dhte_pkg::out_item_t       out_data
);

  import dhte_pkg::*;

  localparam int KEY_W  = 8 * KEY_BYTES;
  localparam int SUM_W  = $clog2(KEY_BYTES * 255 + 1);
  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int PROD_W = 2 * SUM_W;
  localparam int REM_W  = SUM_W + SLOT_W + 1;

  localparam logic [SLOT_W:0]   MOD_HOME = (SLOT_W + 1)'(TABLE_SLOTS);
  localparam logic [SLOT_W:0]   MOD_STEP = (SLOT_W + 1)'(TABLE_SLOTS - 1);
  // floor(2^SUM_W / m): the quotient estimate is low by at most one
  localparam logic [SUM_W:0]    RCP_HOME = (SUM_W + 1)'((1 << SUM_W) / TABLE_SLOTS);
  localparam logic [SUM_W:0]    RCP_STEP = (SUM_W + 1)'((1 << SUM_W) / (TABLE_SLOTS - 1));
  localparam logic [SLOT_W-1:0] CNT_LAST = SLOT_W'(TABLE_SLOTS - 1);

  // Slot memory: {tombstone, key}; valid bits mark slots written since reset
  logic [KEY_W:0]          mem [TABLE_SLOTS];
  logic [KEY_W:0]          rd_data_r;
  logic                    rd_valid_r;
  logic [TABLE_SLOTS-1:0]  valid_r, valid_nxt;
  logic                    rd_en, mem_we;
  logic [KEY_W:0]          mem_wdata;

  state_t                  state_r, state_nxt;
  logic [1:0]              cmd_r, cmd_nxt;
  logic [KEY_W-1:0]        key_r, key_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [SUM_W-1:0]        qa_r, qa_nxt;
  logic [SUM_W-1:0]        qb_r, qb_nxt;
  logic [SLOT_W-1:0]       pos_r, pos_nxt;
  logic [SLOT_W-1:0]       step_r, step_nxt;
  logic [SLOT_W-1:0]       cnt_r, cnt_nxt;
  logic [2:0]              res_status_r, res_status_nxt;
  logic [3:0]              res_slot_r, res_slot_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;

  // Request key masked to its bytes, and its byte sum
  logic [KEY_W-1:0]        in_key;
  logic [SUM_W-1:0]        in_sum;

  always_comb begin
    in_key = in_data.key[KEY_W-1:0];
    in_sum = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      in_sum = in_sum + SUM_W'(in_key[8*b +: 8]);
    end
  end

  // Quotient estimates, then remainders with one correcting subtract
  logic [PROD_W-1:0] qa_prod, qb_prod;
  logic [REM_W-1:0]  ra_raw, rb_raw;
  logic [SLOT_W-1:0] moda_new, modb_new;

  always_comb begin
    qa_prod  = PROD_W'(sum_r) * PROD_W'(RCP_HOME);
    qb_prod  = PROD_W'(sum_r) * PROD_W'(RCP_STEP);
    ra_raw   = REM_W'(sum_r) - REM_W'(qa_r) * REM_W'(MOD_HOME);
    rb_raw   = REM_W'(sum_r) - REM_W'(qb_r) * REM_W'(MOD_STEP);
    moda_new = (ra_raw >= REM_W'(MOD_HOME)) ? SLOT_W'(ra_raw - REM_W'(MOD_HOME))
                                            : SLOT_W'(ra_raw);
    modb_new = (rb_raw >= REM_W'(MOD_STEP)) ? SLOT_W'(rb_raw - REM_W'(MOD_STEP))
                                            : SLOT_W'(rb_raw);
  end

  // Next probe position, (pos + step) mod TABLE_SLOTS
  logic [SLOT_W:0]   pos_sum;
  logic [SLOT_W-1:0] pos_adv;

  always_comb begin
    pos_sum = {1'b0, pos_r} + {1'b0, step_r};
    pos_adv = (pos_sum >= MOD_HOME) ? SLOT_W'(pos_sum - MOD_HOME) : SLOT_W'(pos_sum);
  end

  // Slot contents as seen by the check; unwritten slots read empty
  logic [KEY_W-1:0] slot_key;
  logic             slot_tomb;
  logic             probe_last;

  assign slot_key   = rd_valid_r ? rd_data_r[KEY_W-1:0] : '0;
  assign slot_tomb  = rd_valid_r & rd_data_r[KEY_W];
  assign probe_last = (cnt_r == CNT_LAST);

  // Next state and datapath
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    sum_nxt        = sum_r;
    qa_nxt         = qa_r;
    qb_nxt         = qb_r;
    pos_nxt        = pos_r;
    step_nxt       = step_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    valid_nxt      = valid_r;
    in_ready       = 1'b0;
    rd_en          = 1'b0;
    mem_we         = 1'b0;
    mem_wdata      = {1'b0, key_r};

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt      = in_data.cmd;
          key_nxt      = in_key;
          sum_nxt      = in_sum;
          res_slot_nxt = '0;
          if (in_key == '0 || (in_data.cmd != CMD_INSERT && in_data.cmd != CMD_SEARCH
                               && in_data.cmd != CMD_REMOVE)) begin
            res_status_nxt = STS_BAD_KEY;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end

      // Quotient estimates of the sum for both moduli
      S_HASH: begin
        qa_nxt    = qa_prod[PROD_W-1:SUM_W];
        qb_nxt    = qb_prod[PROD_W-1:SUM_W];
        state_nxt = S_REDUCE;
      end

      // Home slot and probe step from the remainders
      S_REDUCE: begin
        pos_nxt   = moda_new;
        step_nxt  = modb_new + SLOT_W'(1);
        cnt_nxt   = '0;
        state_nxt = S_READ;
      end

      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        state_nxt = S_READ;
        pos_nxt   = pos_adv;
        cnt_nxt   = cnt_r + SLOT_W'(1);
        if (cmd_r == CMD_INSERT) begin
          if (slot_key == '0 || slot_tomb) begin
            mem_we          = 1'b1;
            mem_wdata       = {1'b0, key_r};
            valid_nxt[pos_r] = 1'b1;
            res_status_nxt  = STS_INSERTED;
            res_slot_nxt    = 4'(pos_r);
            pos_nxt         = pos_r;
            state_nxt       = S_RESP;
          end else if (probe_last) begin
            res_status_nxt = STS_FULL;
            res_slot_nxt   = '0;
            state_nxt      = S_RESP;
          end
        end else begin
          if (slot_key == key_r) begin
            res_slot_nxt = 4'(pos_r);
            pos_nxt      = pos_r;
            state_nxt    = S_RESP;
            if (cmd_r == CMD_REMOVE) begin
              mem_we           = 1'b1;
              mem_wdata        = {1'b1, {KEY_W{1'b0}}};
              valid_nxt[pos_r] = 1'b1;
              res_status_nxt   = STS_REMOVED;
            end else begin
              res_status_nxt = STS_FOUND;
            end
          end else if ((slot_key == '0 && !slot_tomb) || probe_last) begin
            res_slot_nxt   = '0;
            res_status_nxt = (cmd_r == CMD_REMOVE) ? STS_REMOVE_MISS : STS_NOT_FOUND;
            state_nxt      = S_RESP;
          end
        end
      end

      // Hand the result to the output register once it is free
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = res_status_r;
          out_data_nxt.slot   = res_slot_r;
          state_nxt           = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    sum_r        <= sum_nxt;
    qa_r         <= qa_nxt;
    qb_r         <= qb_nxt;
    pos_r        <= pos_nxt;
    step_r       <= step_nxt;
    cnt_r        <= cnt_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Slot memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pos_r] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r  <= mem[pos_r];
      rd_valid_r <= valid_r[pos_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
